@@ design/itp_pkg.sv @@
`timescale 1ns / 1ps
package itp_pkg;

  // longest string the offsets track; position and end offset stop here
  localparam int MAX_LEN = 4096;
  localparam int POS_W   = $clog2(MAX_LEN + 1);
  localparam int BASE_W  = 6;
  localparam int ACC_W   = 64;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  // register map, word index taken from paddr[2]
  localparam logic REG_NUMBER_BASE = 1'b0;
  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

  // parse phases
  localparam logic [2:0] PH_WS   = 3'd0;
  localparam logic [2:0] PH_SIGN = 3'd1;
  localparam logic [2:0] PH_ZERO = 3'd2;
  localparam logic [2:0] PH_PFX  = 3'd3;
  localparam logic [2:0] PH_DIG  = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;

  // digit status
  localparam logic [1:0] DS_NONE = 2'd0;
  localparam logic [1:0] DS_SOME = 2'd1;
  localparam logic [1:0] DS_OVF  = 2'd2;

  localparam logic [BASE_W-1:0] NO_DIGIT = 6'd36;
  localparam logic [BASE_W-1:0] MAX_BASE = 6'd36;
  localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;
  localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;
  localparam logic [BASE_W-1:0] BASE_BAD = 6'd1;

  localparam logic [ACC_W-1:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ACC_W-1:0] SAT_NEG = 64'h8000_0000_0000_0000;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;

  typedef struct packed {
    logic [2:0]       phase;
    logic             negative;
    logic [BASE_W-1:0] active_base;
    logic [ACC_W-1:0] accumulator;
    logic [1:0]       digit_status;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] stop_offset;
  } state_t;

  localparam state_t STATE_CLEAR = '{
    phase:        PH_WS,
    negative:     1'b0,
    active_base:  '0,
    accumulator:  '0,
    digit_status: DS_NONE,
    position:     '0,
    stop_offset:  '0
  };

  function automatic logic [BASE_W-1:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'(NO_DIGIT);
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = c - CH_UA + 8'd10;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = c - CH_LA + 8'd10;
    end
    return d[BASE_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] sat_next(input logic [POS_W-1:0] p);
    logic [POS_W:0] n;
    n = {1'b0, p} + (POS_W+1)'(1);
    return (n >= (POS_W+1)'(MAX_LEN)) ? POS_W'(MAX_LEN) : n[POS_W-1:0];
  endfunction

endpackage

@@ design/itp_in_if.sv @@
`timescale 1ns / 1ps
interface itp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

@@ design/itp_out_if.sv @@
`timescale 1ns / 1ps
interface itp_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [itp_pkg::ACC_W-1:0] value;
  logic [itp_pkg::POS_W-1:0]     end_offset;
  logic                          overflowed;

  modport source (output valid, output value, output end_offset, output overflowed,
                  input ready);
  modport sink   (input valid, input value, input end_offset, input overflowed,
                  output ready);
endinterface

@@ design/itp_step.sv @@
`timescale 1ns / 1ps
module itp_step (
  input  itp_pkg::state_t                 st,
  input  logic [7:0]                      ch,
  input  logic [itp_pkg::BASE_W-1:0]      number_base,
  output itp_pkg::state_t                 nx
);

  logic [itp_pkg::BASE_W-1:0] base_now;
  logic [itp_pkg::BASE_W-1:0] dig_base;
  logic [itp_pkg::BASE_W-1:0] dv;
  logic                       is_dig;
  logic                       is_ws;
  logic                       is_x;
  logic                       zero_lead;
  logic [itp_pkg::ACC_W-1:0]  limit;
  logic [69:0]                prod;
  logic [70:0]                sum;
  logic                       over;
  itp_pkg::state_t            dig_nx;

  // base in force for this character; radix is sampled on first non-blank
  assign base_now = (st.phase == itp_pkg::PH_WS) ? number_base : st.active_base;
  assign dig_base = (base_now != '0) ? base_now :
                    (st.phase == itp_pkg::PH_ZERO) ? itp_pkg::BASE_OCT : itp_pkg::BASE_DEC;
  assign dv     = itp_pkg::digit_value(ch);
  assign is_dig = dv < dig_base;
  assign is_ws  = (ch == itp_pkg::CH_SPACE) ||
                  (ch >= itp_pkg::CH_TAB && ch <= itp_pkg::CH_CR);
  assign is_x   = (ch == itp_pkg::CH_LX) || (ch == itp_pkg::CH_UX);
  assign zero_lead = (ch == itp_pkg::CH_0) &&
                     (base_now == '0 || base_now == itp_pkg::BASE_HEX);

  // exact overflow test: acc * base + d > limit
  assign limit = st.negative ? itp_pkg::SAT_NEG : itp_pkg::SAT_POS;
  assign prod  = 70'(st.accumulator) * 70'(dig_base);
  assign sum   = 71'(prod) + 71'(dv);
  assign over  = sum > 71'(limit);

  // outcome of a character taken in a digit phase
  always_comb begin
    dig_nx = st;
    dig_nx.active_base = dig_base;
    if (is_dig) begin
      if (st.digit_status != itp_pkg::DS_OVF) begin
        if (over) begin
          dig_nx.digit_status = itp_pkg::DS_OVF;
        end else begin
          dig_nx.accumulator  = sum[itp_pkg::ACC_W-1:0];
          dig_nx.digit_status = itp_pkg::DS_SOME;
        end
      end
      dig_nx.stop_offset = itp_pkg::sat_next(st.position);
      dig_nx.phase       = itp_pkg::PH_DIG;
    end else begin
      dig_nx.phase = itp_pkg::PH_DONE;
    end
  end

  always_comb begin
    nx = st;
    case (st.phase)
      itp_pkg::PH_WS, itp_pkg::PH_SIGN: begin
        if (st.phase == itp_pkg::PH_WS && is_ws) begin
          nx = st;
        end else if (st.phase == itp_pkg::PH_WS &&
                     (base_now == itp_pkg::BASE_BAD || base_now > itp_pkg::MAX_BASE)) begin
          nx.active_base = base_now;
          nx.phase       = itp_pkg::PH_DONE;
        end else if (st.phase == itp_pkg::PH_WS &&
                     (ch == itp_pkg::CH_MINUS || ch == itp_pkg::CH_PLUS)) begin
          nx.active_base = base_now;
          nx.negative    = (ch == itp_pkg::CH_MINUS);
          nx.phase       = itp_pkg::PH_SIGN;
        end else if (zero_lead) begin
          nx.active_base  = base_now;
          nx.digit_status = itp_pkg::DS_SOME;
          nx.stop_offset  = itp_pkg::sat_next(st.position);
          nx.phase        = itp_pkg::PH_ZERO;
        end else begin
          nx = dig_nx;
        end
      end
      itp_pkg::PH_ZERO: begin
        if (is_x) begin
          nx.active_base = itp_pkg::BASE_HEX;
          nx.phase       = itp_pkg::PH_PFX;
        end else begin
          nx = dig_nx;
        end
      end
      itp_pkg::PH_PFX, itp_pkg::PH_DIG: begin
        nx = dig_nx;
      end
      default: begin
        nx = st;
      end
    endcase
    nx.position = itp_pkg::sat_next(st.position);
  end

endmodule

@@ design/integer_text_parser.sv @@
`timescale 1ns / 1ps
// Streaming text-to-integer parser in the usual strtol manner. One character
// word is taken per clock on the chars channel; the word marked last closes
// the string and yields one result word (value, end_offset, overflowed) on
// the result channel, while all other words yield nothing. Leading blanks
// (space and codes 9 to 13) are skipped, one sign is allowed, a 0x/0X prefix
// is honored for radix 0 or 16, and radix 0 picks octal after a leading zero
// and decimal otherwise. Overflow saturates to the 64-bit signed limit while
// the remaining digits are still consumed. The radix lives in the
// number_base register (byte address 0, reset 10) and is sampled at the
// first non-blank character of each string; a radix of 1 or above 36 gives
// a zero result. Throughput is one character per cycle with no gaps, also
// across string boundaries; only a last word held while the result register
// is still full stalls the input. A result word moves from the input register
// into the result register when its last character leaves the input
// register, and the result register drives the result channel.
// The cycle time is set by the 64 x 6 bit multiply-add and limit compare in
// the step unit, which closes the per-character loop.
module integer_text_parser (
  input  logic                         clk,
  input  logic                         rst,
  itp_in_if.sink                       chars,
  itp_out_if.source                    result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [itp_pkg::ADDR_W-1:0]   paddr,
  input  logic [itp_pkg::DATA_W-1:0]   pwdata,
  output logic [itp_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  // configuration
  logic [itp_pkg::BASE_W-1:0] number_base;
  logic                       cfg_write;

  // input register
  logic       in_valid;
  logic [7:0] in_ch;
  logic       in_last;

  // parse state and its next value
  itp_pkg::state_t state;
  itp_pkg::state_t state_next;

  logic                      advance;
  logic [itp_pkg::ACC_W-1:0] res_value;
  logic [itp_pkg::POS_W-1:0] res_offset;
  logic                      res_ovf;

  // apb register port, no wait states
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == itp_pkg::REG_NUMBER_BASE);
  assign prdata    = (paddr[2] == itp_pkg::REG_NUMBER_BASE) ?
                     itp_pkg::DATA_W'(number_base) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= itp_pkg::BASE_RESET;
    end else if (cfg_write) begin
      number_base <= pwdata[itp_pkg::BASE_W-1:0];
    end
  end

  // the held word moves on unless it closes a string and the result
  // register is still full
  assign advance     = in_valid && (!in_last || !result.valid || result.ready);
  assign chars.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      in_ch   <= chars.ch;
      in_last <= chars.last;
    end
  end

  // one character of work
  itp_step u_step (
    .st          (state),
    .ch          (in_ch),
    .number_base (number_base),
    .nx          (state_next)
  );

  // per-string state returns to its clear value after the last word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itp_pkg::STATE_CLEAR;
    end else if (advance) begin
      state <= in_last ? itp_pkg::STATE_CLEAR : state_next;
    end
  end

  // result formatting from the state after the last character
  always_comb begin
    case (state_next.digit_status)
      itp_pkg::DS_OVF: begin
        res_value = state_next.negative ? itp_pkg::SAT_NEG : itp_pkg::SAT_POS;
      end
      itp_pkg::DS_SOME: begin
        res_value = state_next.negative ? (~state_next.accumulator + 64'd1)
                                        : state_next.accumulator;
      end
      default: begin
        res_value = '0;
      end
    endcase
  end

  assign res_offset = (state_next.digit_status == itp_pkg::DS_NONE) ? '0
                                                                    : state_next.stop_offset;
  assign res_ovf    = (state_next.digit_status == itp_pkg::DS_OVF);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance && in_last) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      result.value      <= res_value;
      result.end_offset <= res_offset;
      result.overflowed <= res_ovf;
    end
  end

endmodule

@@ design/itp_checker.sv @@
`timescale 1ns / 1ps
module itp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             valid,
  input logic                             ready,
  input logic signed [itp_pkg::ACC_W-1:0] value,
  input logic [itp_pkg::POS_W-1:0]        end_offset,
  input logic                             overflowed
);

  // a held result word stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(value) && $stable(end_offset))
    else $error("result changed while stalled");

  // saturation only ever shows a 64-bit limit
  a_sat: assert property (@(posedge clk) disable iff (rst)
    valid && overflowed |->
      (value == itp_pkg::SAT_POS) || (value == itp_pkg::SAT_NEG))
    else $error("overflow without limit value");

  // no digit consumed means nothing parsed
  a_empty: assert property (@(posedge clk) disable iff (rst)
    valid && end_offset == '0 |-> value == '0 && !overflowed)
    else $error("value without consumed digit");

  a_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> end_offset <= itp_pkg::POS_W'(itp_pkg::MAX_LEN))
    else $error("end offset past limit");

  a_reset: assert property (@(posedge clk) rst |=> !valid)
    else $error("result valid after reset");

endmodule

bind integer_text_parser itp_checker u_itp_checker (
  .clk        (clk),
  .rst        (rst),
  .valid      (result.valid),
  .ready      (result.ready),
  .value      (result.value),
  .end_offset (result.end_offset),
  .overflowed (result.overflowed)
);

@@ bench/itp_result_checker.sv @@
`timescale 1ns / 1ps
module itp_result_checker (
  input  logic                       clk,
  input  logic                       rst,
  itp_in_if                          chars,
  itp_out_if                         result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [itp_pkg::ADDR_W-1:0] paddr,
  input  logic [itp_pkg::DATA_W-1:0] pwdata,
  input  logic [itp_pkg::DATA_W-1:0] prdata,
  input  logic                       pready,
  output int                         mismatches,
  output int                         pending
);
  import itp_pkg::*;

  typedef struct packed {
    logic signed [ACC_W-1:0] value;
    logic [POS_W-1:0]        end_offset;
    logic                    overflowed;
  } parse_result_t;

  // shadow of the radix register and of the per-string parse state
  logic [BASE_W-1:0] base_reg;
  logic [2:0]        parse_phase;
  logic              minus;
  logic [BASE_W-1:0] radix;
  logic [ACC_W-1:0]  magnitude;
  logic [1:0]        digit_state;
  logic [POS_W-1:0]  char_pos;
  logic [POS_W-1:0]  stop_pos;
  parse_result_t     results_due[$];

  function automatic logic [BASE_W-1:0] char_digit(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return BASE_W'(c - CH_0);
    if (c >= CH_UA && c <= CH_UZ) return BASE_W'(c - CH_UA + 8'd10);
    if (c >= CH_LA && c <= CH_LZ) return BASE_W'(c - CH_LA + 8'd10);
    return NO_DIGIT;
  endfunction

  function automatic logic [POS_W-1:0] pos_after(input logic [POS_W-1:0] p);
    return (int'(p) + 1 >= MAX_LEN) ? POS_W'(MAX_LEN) : p + 1'b1;
  endfunction

  function automatic void clear_string();
    parse_phase = PH_WS;
    minus       = 1'b0;
    radix       = '0;
    magnitude   = '0;
    digit_state = DS_NONE;
    char_pos    = '0;
    stop_pos    = '0;
  endfunction

  // exact overflow test on the magnitude, sticky once saturated
  function automatic void add_digit(input logic [BASE_W-1:0] d);
    logic [ACC_W-1:0] limit;
    logic [ACC_W-1:0] b;
    limit = minus ? SAT_NEG : SAT_POS;
    b = (radix == '0) ? ACC_W'(BASE_DEC) : ACC_W'(radix);
    if (digit_state != DS_OVF) begin
      if (magnitude > (limit - ACC_W'(d)) / b) begin
        digit_state = DS_OVF;
      end else begin
        magnitude   = magnitude * b + ACC_W'(d);
        digit_state = DS_SOME;
      end
    end
  endfunction

  function automatic void digit_or_stop(input logic [7:0] c, input logic [POS_W-1:0] p);
    logic [BASE_W-1:0] d;
    d = char_digit(c);
    if (d < radix) begin
      add_digit(d);
      stop_pos    = pos_after(p);
      parse_phase = PH_DIG;
    end else begin
      parse_phase = PH_DONE;
    end
  endfunction

  function automatic void first_digit(input logic [7:0] c, input logic [POS_W-1:0] p);
    if (c == CH_0 && (radix == '0 || radix == BASE_HEX)) begin
      digit_state = DS_SOME;
      stop_pos    = pos_after(p);
      parse_phase = PH_ZERO;
    end else begin
      if (radix == '0) radix = BASE_DEC;
      digit_or_stop(c, p);
    end
  endfunction

  function automatic void take_char(input logic [7:0] c, input logic [POS_W-1:0] p);
    case (parse_phase)
      PH_WS: begin
        if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
          radix = base_reg;
          if (radix == BASE_BAD || radix > MAX_BASE) begin
            parse_phase = PH_DONE;
          end else if (c == CH_MINUS || c == CH_PLUS) begin
            minus       = (c == CH_MINUS);
            parse_phase = PH_SIGN;
          end else begin
            first_digit(c, p);
          end
        end
      end
      PH_SIGN: first_digit(c, p);
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          radix       = BASE_HEX;
          parse_phase = PH_PFX;
        end else begin
          if (radix == '0) radix = BASE_OCT;
          digit_or_stop(c, p);
        end
      end
      PH_PFX: begin
        if (char_digit(c) < BASE_HEX) digit_or_stop(c, p);
        else parse_phase = PH_DONE;
      end
      PH_DIG: digit_or_stop(c, p);
      default: ;
    endcase
  endfunction

  function automatic void step_parser(input logic [7:0] c, input logic fin);
    logic [POS_W-1:0] p;
    parse_result_t    r;
    p = char_pos;
    take_char(c, p);
    char_pos = pos_after(p);
    if (fin) begin
      case (digit_state)
        DS_OVF:  r.value = minus ? SAT_NEG : SAT_POS;
        DS_SOME: r.value = minus ? -magnitude : magnitude;
        default: r.value = '0;
      endcase
      r.end_offset = (digit_state == DS_NONE) ? '0 : stop_pos;
      r.overflowed = (digit_state == DS_OVF);
      results_due.push_back(r);
      clear_string();
    end
  endfunction

  always @(posedge clk) begin
    parse_result_t want;
    if (rst) begin
      base_reg = BASE_RESET;
      clear_string();
      results_due.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pready && paddr[2] == REG_NUMBER_BASE) begin
        if (pwrite) begin
          base_reg = pwdata[BASE_W-1:0];
        end else if (prdata !== DATA_W'(base_reg)) begin
          mismatches++;
          $display("%0t: number_base read expected %0d got %0d", $time, base_reg, prdata);
        end
      end
      if (result.valid && result.ready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, expected none got value %0d end_offset %0d ovf %0b",
                   $time, result.value, result.end_offset, result.overflowed);
        end else begin
          want = results_due.pop_front();
          if (result.value !== want.value) begin
            mismatches++;
            $display("%0t: value expected %0d got %0d", $time, want.value, result.value);
          end
          if (result.end_offset !== want.end_offset) begin
            mismatches++;
            $display("%0t: end_offset expected %0d got %0d", $time, want.end_offset,
                     result.end_offset);
          end
          if (result.overflowed !== want.overflowed) begin
            mismatches++;
            $display("%0t: overflowed expected %0b got %0b", $time, want.overflowed,
                     result.overflowed);
          end
        end
      end
      if (chars.valid && chars.ready) step_parser(chars.ch, chars.last);
    end
    pending = results_due.size();
  end

endmodule

@@ bench/tb_integer_text_parser.sv @@
`timescale 1ns / 1ps
module tb_integer_text_parser;
  import itp_pkg::*;

  // slowest run: about 700 words at worst gap plus output stall, plus drains
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 420;
  localparam int RADIX_PHASES = 11;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [ADDR_W-1:0] BASE_ADDR = {REG_NUMBER_BASE, 2'b00};

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int                mismatches;
  int                pending;
  int                items_sent;
  int                cycle_count = 0;
  logic              quiet_in;
  byte unsigned      text[$];

  itp_in_if  chars_if ();
  itp_out_if result_if ();

  integer_text_parser uut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // watches both channels and the register port, predicts and compares
  itp_result_checker result_check (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars_if),
    .result     (result_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: random stall before each word, with runs of no stall at all
  initial begin
    int   stall;
    logic quiet_out;
    result_if.ready = 1'b0;
    quiet_out = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) quiet_out = !quiet_out;
      stall = quiet_out ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        result_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_if.ready = 1'b1;
      do @(posedge clk); while (!result_if.valid);
      @(negedge clk);
    end
  end

  // one character word; starts and ends on a falling edge, valid left high
  // so a back-to-back word keeps it up without a drop
  task automatic drive_char(input logic [7:0] c, input logic fin);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      chars_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    chars_if.valid = 1'b1;
    chars_if.ch    = c;
    chars_if.last  = fin;
    do @(posedge clk); while (!chars_if.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // send the built string, last marked on its final character
  task automatic send_text();
    foreach (text[i]) drive_char(text[i], i == text.size() - 1);
    text.delete();
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endtask

  task automatic parse_str(input string s);
    add_str(s);
    send_text();
  endtask

  // stop sending and let every pending word drain, then a few spare cycles
  task automatic settle();
    chars_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [DATA_W-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = BASE_ADDR;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // radix change only with the parser idle; read back to check the register
  task automatic set_base(input int radix_val);
    settle();
    apb_access(1'b1, DATA_W'(radix_val));
    apb_access(1'b0, '0);
  endtask

  function automatic logic [7:0] blank_char();
    if ($urandom_range(0, 1)) return CH_SPACE;
    return 8'($urandom_range(CH_TAB, CH_CR));
  endfunction

  // digit of value d with random letter case
  function automatic logic [7:0] digit_char(input int d);
    if (d < 10) return CH_0 + 8'(d);
    return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(d - 10);
  endfunction

  task automatic push_magnitude(input logic [ACC_W-1:0] m, input int radix_val);
    byte unsigned     digs[$];
    logic [ACC_W-1:0] r;
    r = ACC_W'(radix_val);
    do begin
      digs.push_front(digit_char(int'(m % r)));
      m = m / r;
    end while (m != 0);
    foreach (digs[i]) text.push_back(digs[i]);
  endtask

  // blanks, sign, optional prefix, digits of the effective radix, junk tail;
  // near_limit puts a magnitude close to or past the 64-bit range
  task automatic build_number(input int radix_now, input logic near_limit);
    int               eff;
    int               n;
    logic [ACC_W-1:0] m;
    repeat ($urandom_range(0, 3)) text.push_back(blank_char());
    case ($urandom_range(0, 3))
      0: text.push_back(CH_MINUS);
      1: text.push_back(CH_PLUS);
      default: ;
    endcase
    eff = radix_now;
    if (radix_now == BASE_BAD || radix_now > MAX_BASE) begin
      eff = BASE_DEC;
    end else if (radix_now == 0 || radix_now == BASE_HEX) begin
      case ($urandom_range(0, 2))
        0: begin
          text.push_back(CH_0);
          text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
          eff = BASE_HEX;
        end
        1: begin
          text.push_back(CH_0);
          if (radix_now == 0) eff = BASE_OCT;
        end
        default: if (radix_now == 0) eff = BASE_DEC;
      endcase
    end
    if (near_limit) begin
      case ($urandom_range(0, 2))
        0: m = {$urandom, $urandom};
        1: m = SAT_NEG - 64'd2 + ACC_W'($urandom_range(0, 4));
        default: m = {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
      push_magnitude(m, eff);
    end else begin
      n = $urandom_range(0, 20);
      repeat (n) text.push_back(digit_char($urandom_range(0, eff - 1)));
    end
    if ($urandom_range(0, 1)) begin
      repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
    end
    if (text.size() == 0) text.push_back(blank_char());
  endtask

  // malformed shapes: doubled sign, prefix with no hex digit, sign cut off by a blank, split numbers
  task automatic build_broken();
    case ($urandom_range(0, 3))
      0: begin
        text.push_back(CH_PLUS);
        text.push_back(CH_MINUS);
        add_str("123");
      end
      1: begin
        text.push_back(CH_0);
        text.push_back(CH_LX);
        text.push_back($urandom_range(0, 1) ? 8'($urandom_range(128, 255)) : CH_LX);
      end
      2: begin
        text.push_back(blank_char());
        text.push_back(CH_MINUS);
        text.push_back(blank_char());
        add_str("77");
      end
      default: begin
        add_str("42");
        text.push_back(blank_char());
        add_str("58");
      end
    endcase
  endtask

  initial begin
    int radix_plan[RADIX_PHASES];
    int phase_start;
    int radix_now;
    radix_plan = '{0, 2, 36, 16, 1, 10, 63, 8, 37, 0, 5};
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    chars_if.valid = 1'b0;
    chars_if.ch    = '0;
    chars_if.last  = 1'b0;
    quiet_in       = 1'b0;
    items_sent     = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, radix 10 from reset: signs, both 64-bit limits, stop chars
    parse_str("  \t-42");
    parse_str("+9223372036854775807");
    parse_str("9223372036854775808");
    parse_str("-9223372036854775808");
    parse_str("-9223372036854775809");
    parse_str("12a3");
    parse_str("-");
    // whitespace only, every blank code
    for (int c = CH_TAB; c <= CH_CR; c++) text.push_back(8'(c));
    text.push_back(CH_SPACE);
    send_text();
    // code 0 and a code above 127 end the number
    add_str("7");
    text.push_back(8'h00);
    send_text();
    add_str("5");
    text.push_back(8'hFF);
    send_text();

    // automatic radix: hex prefix, bare prefix, prefix without digit, octal
    set_base(0);
    parse_str("0x1F");
    parse_str("0X");
    parse_str("0xg");
    parse_str("017");
    parse_str("089");
    parse_str(" -0x8000000000000000");
    parse_str("0x10000000000000000");

    set_base(16);
    parse_str("-0xffffffffffffffff");
    set_base(36);
    parse_str("-zZ");
    set_base(2);
    parse_str("1012");
    // invalid radix values give a zero result
    set_base(1);
    parse_str("5");
    set_base(63);
    parse_str("+12");

    // random part, one radix per phase, extremes included
    foreach (radix_plan[k]) begin
      radix_now = radix_plan[k];
      if (k == RADIX_PHASES - 1) radix_now = $urandom_range(3, 35);
      set_base(radix_now);
      phase_start = items_sent;
      while (items_sent - phase_start < RANDOM_ITEMS / RADIX_PHASES) begin
        quiet_in = ($urandom_range(0, 5) == 0);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: build_number(radix_now, 1'b0);
          5, 6:          build_number(radix_now, 1'b1);
          7, 8:          repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
          default:       build_broken();
        endcase
        send_text();
        // now and then hold off until every word has come back
        if ($urandom_range(0, 15) == 0) settle();
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
